// ===== hdl/line_editor_stack_buffer_macros.svh =====
`ifndef LINE_EDITOR_STACK_BUFFER_MACROS_SVH
`define LINE_EDITOR_STACK_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LESB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LESB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lesb_pkg.sv =====
package lesb_pkg;

    localparam int CHAR_W         = 8;
    localparam int CFG_W          = 6;
    localparam int LINE_DEPTH_DEF = 63;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 6'd63;

    // Editing characters
    localparam logic [CHAR_W-1:0] CH_ERASE_CHAR = 8'h23;  // '#'
    localparam logic [CHAR_W-1:0] CH_KILL_LINE  = 8'h5C;  // '\'
    localparam logic [CHAR_W-1:0] CH_ERASE_WORD = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_EMIT_LINE  = 8'h40;  // '@'
    localparam logic [CHAR_W-1:0] CH_END_MARK   = 8'h7E;  // '~'
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              is_last;
        logic              end_of_text;
    } out_item_t;

endpackage

// ===== hdl/lesb_ram.sv =====
module lesb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/lesb_out_stage.sv =====
module lesb_out_stage
    import lesb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  out_item_t         item,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // The slot can take a new item when empty or when the current one leaves.
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.out_char;
    assign m_tlast  = item_reg.is_last;
    assign m_tuser  = item_reg.end_of_text;

endmodule

// ===== hdl/line_editor_stack_buffer.sv =====
// Line editor with a stack-style line buffer.
// Input stream (s_t*): one character byte per transfer. Output stream (m_t*):
// emitted line characters oldest-first, then a newline with m_tlast set;
// m_tuser marks the newline that closes the text after '~'.
// cfg_we/cfg_wdata write max_line_length (reset 63, capped at LINE_DEPTH).
// Characters live in one single-port-read RAM of LINE_DEPTH bytes with a
// registered read; the sequencer reads, compares and streams entries from it.
// Handling per accepted item:
//   plain character, '#', '\', linefeed: done in idle, s_tready stays high.
//   '$': pops characters back to and including the nearest space, or until empty.
//   '@', '~', or a character that forces the line out: the stored characters
//   are read from the RAM into the output register, one character per cycle
//   while the receiver takes them, the newline last.
// A stalled receiver holds the output register and freezes the walk through
// the RAM; s_tready stays low until the sequencer is back in idle.
// Reset clears the fill count, the end-of-text flag and the output valid flag;
// the RAM is not cleared since only entries below the fill count are read.
// After '~' every input is taken and dropped until reset.
module line_editor_stack_buffer
    import lesb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] in_char
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
    output logic              m_tlast,   // is_last
    output logic              m_tuser,   // [0] end_of_text
    // Configuration
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata  // max_line_length
);

    localparam int AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W = $clog2(LINE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;  // stream stored characters
    localparam logic [1:0] ST_NL   = 2'd2;  // closing newline
    localparam logic [1:0] ST_WORD = 2'd3;  // pop back to a space

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              finished_reg, finished_next;
    logic              eot_reg, eot_next;
    logic              push_pend_reg, push_pend_next;
    logic [CHAR_W-1:0] push_char_reg, push_char_next;
    logic [CFG_W-1:0]  max_len_reg;

    logic              accept;
    logic              line_full;
    logic [CNT_W-1:0]  fill_dec;
    logic [CNT_W-1:0]  k_inc;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;

    logic              out_load;
    logic              out_free;
    out_item_t         out_item;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fill_dec = fill_reg - 1'b1;
    assign k_inc    = k_reg + 1'b1;

    // The effective limit is min(max_line_length, LINE_DEPTH); since the fill
    // never exceeds the depth, compare against each bound separately.
    assign line_full = (CMP_W'(fill_reg) >= CMP_W'(max_len_reg)) ||
                       (fill_reg == DEPTH_CNT);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        finished_next  = finished_reg;
        eot_next       = eot_reg;
        push_pend_next = push_pend_reg;
        push_char_next = push_char_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_reg[AW-1:0];
        wr_data        = s_tdata;
        rd_en          = 1'b0;
        rd_addr        = fill_dec[AW-1:0];
        out_load       = 1'b0;
        out_item       = '{out_char: rd_data, is_last: 1'b0, end_of_text: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !finished_reg)
                begin
                    case (s_tdata)
                        CH_END_MARK:
                        begin
                            finished_next  = 1'b1;
                            eot_next       = 1'b1;
                            push_pend_next = 1'b0;
                            k_next         = '0;
                            rd_addr        = '0;
                            rd_en          = (fill_reg != '0);
                            state_next     = (fill_reg != '0) ? ST_EMIT : ST_NL;
                        end
                        CH_NEWLINE:
                        begin
                            // drop
                        end
                        CH_KILL_LINE:
                        begin
                            fill_next = '0;
                        end
                        CH_ERASE_CHAR:
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_dec;
                            end
                        end
                        CH_EMIT_LINE:
                        begin
                            eot_next       = 1'b0;
                            push_pend_next = 1'b0;
                            k_next         = '0;
                            rd_addr        = '0;
                            rd_en          = (fill_reg != '0);
                            state_next     = (fill_reg != '0) ? ST_EMIT : ST_NL;
                        end
                        CH_ERASE_WORD:
                        begin
                            if (fill_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                fill_next  = fill_dec;
                                state_next = ST_WORD;
                            end
                        end
                        default:
                        begin
                            if (line_full)
                            begin
                                // force the line out, push the character after it
                                eot_next       = 1'b0;
                                push_pend_next = 1'b1;
                                push_char_next = s_tdata;
                                k_next         = '0;
                                rd_addr        = '0;
                                rd_en          = (fill_reg != '0);
                                state_next     = (fill_reg != '0) ? ST_EMIT : ST_NL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                // rd_data holds entry k; advance only when the output slot frees
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (k_inc == fill_reg)
                    begin
                        state_next = ST_NL;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_inc[AW-1:0];
                        k_next  = k_inc;
                    end
                end
            end
            ST_NL:
            begin
                out_item = '{out_char: CH_NEWLINE, is_last: 1'b1, end_of_text: eot_reg};
                if (out_free)
                begin
                    out_load   = 1'b1;
                    fill_next  = '0;
                    state_next = ST_IDLE;
                    if (push_pend_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = push_char_reg;
                        fill_next = CNT_W'(1);
                    end
                end
            end
            ST_WORD:
            begin
                // rd_data holds the entry just popped
                if ((rd_data == CH_SPACE) || (fill_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    fill_next = fill_dec;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            k_reg         <= '0;
            finished_reg  <= 1'b0;
            eot_reg       <= 1'b0;
            push_pend_reg <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            finished_reg  <= finished_next;
            eot_reg       <= eot_next;
            push_pend_reg <= push_pend_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        push_char_reg <= push_char_next;
    end

    lesb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lesb_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .item     (out_item),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/lesb_checker.sv =====
`include "line_editor_stack_buffer_macros.svh"

module lesb_checker
    import lesb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [CHAR_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // A stalled output transfer stays offered.
    `LESB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output dropped while stalled")

    // Every line closes with a newline character.
    `LESB_ASSERT_SAME(a_last_is_nl, m_tvalid && m_tlast, m_tdata == CH_NEWLINE, "tlast without newline")

    // End of text only rides on the closing newline.
    `LESB_ASSERT_SAME(a_eot_on_last, m_tvalid && m_tuser, m_tlast, "end of text on a line character")

    // Nothing follows the end-of-text newline.
    `LESB_ASSERT_NEXT(a_quiet_after_eot, m_tvalid && m_tready && m_tuser, !m_tvalid, "output after end of text")

endmodule

bind line_editor_stack_buffer lesb_checker u_lesb_checker (.*);
